// ===== rtl/als_pkg.sv =====
// Shared types and constants for the anti-aliased line stepper.
// Used by every module of the block; depends on nothing else.
package als_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int RGB_BITS    = 24;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FRAC_BITS:0]    frac_t;
  typedef logic [RGB_BITS-1:0]   rgb_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_t;

  typedef struct packed {
    func_t  func;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    rgb_t   line_rgb;
  } in_item_t;

  typedef struct packed {
    coord_t main_x;
    coord_t main_y;
    rgb_t   main_rgb;
    coord_t side_x;
    coord_t side_y;
    rgb_t   side_rgb;
    logic   side_valid;
    logic   last;
  } out_item_t;

  // Command passed from the front end to the stepping back end.
  typedef struct packed {
    logic   is_load;
    logic   steep;
    logic   y_desc;
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    frac_t  gradient;
    rgb_t   rgb;
  } cmd_t;

endpackage

// ===== rtl/als_front.sv =====
// Front end: accepts transactions, orders and classifies line loads and
// computes the gradient with a bit-serial restoring divider. Uses als_pkg.
module als_front
  import als_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output cmd_t     q_data
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ISSUE
  } state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  logic [COORD_BITS:0]  rem_r;
  coord_t               div_r;
  logic                 zero_r;
  logic [CNT_W-1:0]     cnt_r;
  frac_t                quot_r;

  // Load classification.
  logic   swap;
  coord_t xa, ya, xb, yb, dx, dy, major_len, minor_len;
  logic   y_desc, steep;

  always_comb begin
    swap      = in_data.x_end < in_data.x_start;
    xa        = swap ? in_data.x_end   : in_data.x_start;
    ya        = swap ? in_data.y_end   : in_data.y_start;
    xb        = swap ? in_data.x_start : in_data.x_end;
    yb        = swap ? in_data.y_start : in_data.y_end;
    dx        = xb - xa;
    y_desc    = !(yb > ya);
    dy        = y_desc ? (ya - yb) : (yb - ya);
    steep     = dx < dy;
    major_len = steep ? dy : dx;
    minor_len = steep ? dx : dy;
  end

  // One quotient bit per cycle.
  logic                trial;
  logic [COORD_BITS:0] rem_left;

  always_comb begin
    trial    = rem_r >= {1'b0, div_r};
    rem_left = trial ? (rem_r - {1'b0, div_r}) : rem_r;
  end

  logic load_acc;

  always_comb begin
    in_ready = (state_r == ST_IDLE) && q_ready;
    load_acc = in_valid && in_ready && (in_data.func == FUNC_LOAD);
    q_valid  = 1'b0;
    q_data   = cmd_r;
    if (state_r == ST_ISSUE) begin
      q_valid         = 1'b1;
      q_data.gradient = zero_r ? '0 : quot_r;
    end else if ((state_r == ST_IDLE) && in_valid && (in_data.func == FUNC_STEP)) begin
      q_valid        = 1'b1;
      q_data.is_load = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (load_acc) begin
            cmd_r.is_load   <= 1'b1;
            cmd_r.steep     <= steep;
            cmd_r.y_desc    <= y_desc;
            cmd_r.major_pos <= steep ? ya : xa;
            cmd_r.major_end <= steep ? yb : xb;
            cmd_r.minor_pos <= steep ? xa : ya;
            cmd_r.gradient  <= '0;
            cmd_r.rgb       <= in_data.line_rgb;
            rem_r           <= {1'b0, minor_len};
            div_r           <= major_len;
            zero_r          <= (major_len == '0);
            cnt_r           <= CNT_W'(FRAC_BITS);
            quot_r          <= '0;
            state_r         <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          quot_r <= {quot_r[FRAC_BITS-1:0], trial};
          rem_r  <= {rem_left[COORD_BITS-1:0], 1'b0};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (q_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/als_queue.sv =====
// Small command FIFO between the front end and the back end.
// Uses cmd_t from als_pkg.
module als_queue
  import als_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/als_back.sv =====
// Back end: holds the active line, emits one pixel pair per step command while
// a line is active, into an output register, and advances the coverage error. Uses als_pkg.
module als_back
  import als_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  cmd_t      q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam frac_t FRAC_ONE = frac_t'(1) << FRAC_BITS;

  function automatic rgb_t scale_rgb(rgb_t rgb, frac_t weight);
    logic [FRAC_BITS+8:0] prod;
    rgb_t                 res;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      prod            = rgb[8*ch +: 8] * weight;
      res[8*ch +: 8]  = prod[FRAC_BITS +: 8];
    end
    return res;
  endfunction

  logic      active_r, steep_r, y_desc_r;
  coord_t    major_r, end_r, minor_r;
  frac_t     cov_r, grad_r;
  rgb_t      rgb_r;
  logic      out_valid_r;
  out_item_t out_r;

  logic      pop, do_step;
  out_item_t pix;
  frac_t     cov_sum;

  assign q_ready   = !out_valid_r || out_ready;
  assign pop       = q_valid && q_ready;
  assign do_step   = pop && !q_data.is_load && active_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cov_sum   = cov_r + grad_r;

  always_comb begin
    pix.main_rgb = scale_rgb(rgb_r, FRAC_ONE - cov_r);
    pix.side_rgb = scale_rgb(rgb_r, cov_r);
    pix.last     = major_r == end_r;
    if (steep_r) begin
      pix.main_x     = minor_r;
      pix.main_y     = major_r;
      pix.side_x     = minor_r + 1'b1;
      pix.side_y     = major_r;
      pix.side_valid = minor_r != '1;
    end else begin
      pix.main_x = major_r;
      pix.main_y = minor_r;
      pix.side_x = major_r;
      if (y_desc_r) begin
        pix.side_y     = minor_r - 1'b1;
        pix.side_valid = minor_r != '0;
      end else begin
        pix.side_y     = minor_r + 1'b1;
        pix.side_valid = minor_r != '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A new pixel pair refills the output register in the cycle the old
      // one leaves, so the two never collide.
      if (do_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop && q_data.is_load) begin
        active_r <= 1'b1;
        steep_r  <= q_data.steep;
        y_desc_r <= q_data.y_desc;
        major_r  <= q_data.major_pos;
        end_r    <= q_data.major_end;
        minor_r  <= q_data.minor_pos;
        grad_r   <= q_data.gradient;
        rgb_r    <= q_data.rgb;
        cov_r    <= '0;
      end else if (do_step) begin
        out_r <= pix;
        if (pix.last) begin
          active_r <= 1'b0;
        end else begin
          major_r <= (steep_r && y_desc_r) ? major_r - 1'b1 : major_r + 1'b1;
          cov_r   <= {1'b0, cov_sum[FRAC_BITS-1:0]};
          if (cov_sum[FRAC_BITS]) begin
            minor_r <= (!steep_r && y_desc_r) ? minor_r - 1'b1 : minor_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/antialiased_line_stepper.sv =====
// Top level of the anti-aliased line stepper.
// Instantiates als_front, als_queue and als_back; uses als_pkg.

// The block draws an anti-aliased line one pixel pair at a time. A load
// transaction (func = 0) supplies two endpoints and an RGB888 color and
// produces no result; a step transaction (func = 1) produces one result
// holding the main pixel, its neighbor across the line, both colors
// weighted by the coverage error, a flag telling whether the neighbor is on
// the canvas and a last flag on the end point. After the last step the line
// is inactive and further steps produce nothing until the next load. Step
// transactions flow at one per clock cycle while the queue has room. A load
// occupies the front end while it is accepted, while the serial gradient
// divider works out its FRAC_BITS + 1 quotient bits and until the command
// is handed to the queue; only then is the next transaction taken. Steps
// already queued keep draining from the back end meanwhile, and a result
// waiting in the output register does not block the input side until the
// queue fills.
module antialiased_line_stepper
  import als_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Front-to-queue and queue-to-back command transactions.
  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic b_valid, b_ready;
  cmd_t b_cmd;

  als_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_cmd)
  );

  als_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd)
  );

  als_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_data    (b_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/antialiased_line_stepper_test.sv =====
// Self-checking testbench for the anti-aliased line stepper.
// Depends on als_pkg and antialiased_line_stepper from the RTL.
`timescale 1ns / 100ps

module antialiased_line_stepper_test;
  import als_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  // A load holds the input side only until its gradient is divided and handed on, so this is generous.
  localparam int HANG_LIMIT = 2000;
  // Cycles to wait after the last expected pixel pair, to catch extras.
  localparam int DRAIN_CYCLES = 40;
  // Percentage of cycles in which each side idles outside the quiet stretch.
  localparam int IDLE_PCT = 29;
  // Number of counted transactions in the random part.
  localparam int RANDOM_ITEMS = 1800;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  antialiased_line_stepper u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Transactions waiting to be driven, and pixel pairs the line walk owes.
  in_item_t  pending_items[$];
  out_item_t pairs_due[$];
  out_item_t pair_want;

  int error_count = 0;
  int taken_count = 0;
  int idle_cycles = 0;
  logic quiet_stretch;

  // Both sides stop idling while this window of input transactions passes.
  assign quiet_stretch = (taken_count >= 800) && (taken_count < 1100);

  // -------------------------------------------------------------------------
  // Line walk state. It mirrors what the block should hold after each
  // accepted transaction; everything starts at zero, and the line is inactive as after reset.
  // -------------------------------------------------------------------------
  logic   walk_on = 1'b0;
  logic   walk_steep = 1'b0;
  logic   walk_ydesc = 1'b0;
  coord_t walk_major = '0;
  coord_t walk_major_end = '0;
  coord_t walk_minor = '0;
  frac_t  walk_cov = '0;
  frac_t  walk_grad = '0;
  rgb_t   walk_rgb = '0;

  // Each 8-bit channel is multiplied by a weight in units of 2^-FRAC_BITS
  // and the product is truncated.
  function automatic rgb_t weigh_rgb(input rgb_t color, input frac_t weight);
    rgb_t        scaled;
    int unsigned prod;
    scaled = '0;
    for (int k = 0; k < 3; k++) begin
      prod = color[8*k +: 8] * weight;
      scaled[8*k +: 8] = 8'(prod >> FRAC_BITS);
    end
    return scaled;
  endfunction

  // Advances the line walk by one accepted transaction and queues the pixel
  // pair it should produce, if any.
  task automatic trace_line(input in_item_t item);
    coord_t                       xa, ya, xb, yb, tmp;
    coord_t                       dx, dy, major_len, minor_len;
    logic [COORD_BITS+FRAC_BITS-1:0] quot;
    logic [FRAC_BITS+1:0]         cov_sum;
    out_item_t                    pair;
    if (item.func == FUNC_LOAD) begin
      xa = item.x_start;
      ya = item.y_start;
      xb = item.x_end;
      yb = item.y_end;
      // Endpoints are ordered by x; the y values travel with their x.
      if (xb < xa) begin
        tmp = xa; xa = xb; xb = tmp;
        tmp = ya; ya = yb; yb = tmp;
      end
      dx = xb - xa;
      dy = (yb > ya) ? yb - ya : ya - yb;
      // A horizontal line counts as descending.
      walk_ydesc = !(yb > ya);
      walk_steep = dx < dy;
      if (walk_steep) begin
        walk_major = ya;
        walk_major_end = yb;
        walk_minor = xa;
        major_len = dy;
        minor_len = dx;
      end else begin
        walk_major = xa;
        walk_major_end = xb;
        walk_minor = ya;
        major_len = dx;
        minor_len = dy;
      end
      // A zero-length line has no slope and yields a single pixel pair.
      if (major_len == '0) begin
        walk_grad = '0;
      end else begin
        quot = {minor_len, {FRAC_BITS{1'b0}}} / major_len;
        walk_grad = quot[FRAC_BITS:0];
      end
      walk_cov = '0;
      walk_rgb = item.line_rgb;
      walk_on = 1'b1;
    end else if (walk_on) begin
      pair = '0;
      if (walk_steep) begin
        pair.main_x = walk_minor;
        pair.main_y = walk_major;
        pair.side_x = walk_minor + 1'b1;
        pair.side_y = walk_major;
        pair.side_valid = (walk_minor != '1);
      end else begin
        pair.main_x = walk_major;
        pair.main_y = walk_minor;
        pair.side_x = walk_major;
        if (walk_ydesc) begin
          pair.side_y = walk_minor - 1'b1;
          pair.side_valid = (walk_minor != '0);
        end else begin
          pair.side_y = walk_minor + 1'b1;
          pair.side_valid = (walk_minor != '1);
        end
      end
      pair.main_rgb = weigh_rgb(walk_rgb, frac_t'(1 << FRAC_BITS) - walk_cov);
      pair.side_rgb = weigh_rgb(walk_rgb, walk_cov);
      pair.last = (walk_major == walk_major_end);
      pairs_due.push_back(pair);

      if (pair.last) begin
        walk_on = 1'b0;
      end else begin
        if (walk_steep && walk_ydesc) begin
          walk_major = walk_major - 1'b1;
        end else begin
          walk_major = walk_major + 1'b1;
        end
        // The error carries into the minor axis once it reaches one.
        cov_sum = walk_cov + walk_grad;
        if (cov_sum >= (1 << FRAC_BITS)) begin
          cov_sum = cov_sum - (FRAC_BITS+2)'(1 << FRAC_BITS);
          if (!walk_steep && walk_ydesc) begin
            walk_minor = walk_minor - 1'b1;
          end else begin
            walk_minor = walk_minor + 1'b1;
          end
        end
        walk_cov = cov_sum[FRAC_BITS:0];
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers.
  // -------------------------------------------------------------------------
  task automatic queue_item(input func_t f, input coord_t xs, input coord_t ys,
                            input coord_t xe, input coord_t ye, input rgb_t color);
    in_item_t item;
    item.func = f;
    item.x_start = xs;
    item.y_start = ys;
    item.x_end = xe;
    item.y_end = ye;
    item.line_rgb = color;
    pending_items.push_back(item);
  endtask

  // Step transactions carry random payload, which the block must ignore.
  task automatic queue_steps(input int count);
    for (int k = 0; k < count; k++) begin
      queue_item(FUNC_STEP, coord_t'($urandom()), coord_t'($urandom()),
                 coord_t'($urandom()), coord_t'($urandom()), rgb_t'($urandom()));
    end
  endtask

  // Number of steps that walks a line from end to end.
  function automatic int line_steps(input coord_t xs, input coord_t ys,
                                    input coord_t xe, input coord_t ye);
    int adx, ady;
    adx = (xe > xs) ? xe - xs : xs - xe;
    ady = (ye > ys) ? ye - ys : ys - ye;
    return ((adx > ady) ? adx : ady) + 1;
  endfunction

  // Coordinates favor the canvas border so that off-canvas neighbors occur.
  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom_range((1 << COORD_BITS) - 1));
    endcase
  endfunction

  function automatic coord_t near_coord(input coord_t base, input int span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
    return coord_t'(v);
  endfunction

  // -------------------------------------------------------------------------
  // Input driver. A transaction is taken when valid and ready were both high
  // before the edge; the line walk is advanced right there.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        trace_line(in_data);
        taken_count <= taken_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 &&
            (quiet_stretch || $urandom_range(99) >= IDLE_PCT)) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, off during the quiet stretch.
  always @(posedge clk) begin
    out_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
  end

  // -------------------------------------------------------------------------
  // Result monitor. Every accepted pixel pair is matched against the oldest
  // one owed, field by field.
  // -------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pairs_due.size() == 0) begin
        $display("%0t ns: unexpected pixel pair, expected none, actual %h",
                 $time, out_data);
        error_count++;
      end else begin
        pair_want = pairs_due.pop_front();
        check_field("main_x", 32'(pair_want.main_x), 32'(out_data.main_x));
        check_field("main_y", 32'(pair_want.main_y), 32'(out_data.main_y));
        check_field("main_rgb", 32'(pair_want.main_rgb), 32'(out_data.main_rgb));
        check_field("side_x", 32'(pair_want.side_x), 32'(out_data.side_x));
        check_field("side_y", 32'(pair_want.side_y), 32'(out_data.side_y));
        check_field("side_rgb", 32'(pair_want.side_rgb), 32'(out_data.side_rgb));
        check_field("side_valid", 32'(pair_want.side_valid), 32'(out_data.side_valid));
        check_field("last", 32'(pair_want.last), 32'(out_data.last));
      end
    end
  end

  // Watchdog: the run is hung if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, HANG_LIMIT);
        $display("antialiased_line_stepper_test: done, errors");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run.
  // -------------------------------------------------------------------------
  initial begin
    int     sel, span, full, nsteps, gen_count;
    coord_t xs, ys, xe, ye;
    rgb_t   color;

    // Directed part. A step with no line in progress yields nothing.
    queue_steps(1);
    // Zero-length line at the origin: one pair, neighbor off the canvas.
    queue_item(FUNC_LOAD, '0, '0, '0, '0, 24'hFFFFFF);
    queue_steps(1);
    // The line has ended, so this step yields nothing.
    queue_steps(1);
    // Horizontal line given right to left on the top row of coordinates.
    queue_item(FUNC_LOAD, '1, '1, 12'd4093, '1, 24'h80FF01);
    queue_steps(3);
    // Vertical line on the last column, walking down; neighbor off canvas.
    queue_item(FUNC_LOAD, '1, 12'd13, '1, 12'd11, 24'hFFFFFF);
    queue_steps(3);
    // Shallow ascending line into the last row, gradient of one third.
    queue_item(FUNC_LOAD, '0, 12'd4094, 12'd3, '1, 24'h00FF00);
    queue_steps(4);
    // A diagonal carries on every step; it is cut short by a new load.
    queue_item(FUNC_LOAD, 12'd10, 12'd20, 12'd12, 12'd22, 24'hFFFFFF);
    queue_steps(2);
    // Steep ascending line given right to left.
    queue_item(FUNC_LOAD, 12'd7, 12'd3, 12'd6, 12'd0, 24'h010203);
    queue_steps(4);

    // Random part: mostly complete short lines with random content, some
    // cut short by the next load, some followed by steps that are ignored.
    gen_count = 0;
    while (gen_count < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      span = (sel < 80) ? $urandom_range(8) :
             (sel < 97) ? $urandom_range(40, 9) : $urandom_range(300, 41);
      xs = pick_coord();
      ys = pick_coord();
      xe = near_coord(xs, span);
      ye = near_coord(ys, span);
      color = ($urandom_range(7) == 0) ? 24'hFFFFFF : rgb_t'($urandom());
      full = line_steps(xs, ys, xe, ye);
      queue_item(FUNC_LOAD, xs, ys, xe, ye, color);
      case ($urandom_range(19))
        0:       nsteps = $urandom_range(full - 1);
        1:       nsteps = full + $urandom_range(3, 1);
        default: nsteps = full;
      endcase
      queue_steps(nsteps);
      gen_count += 1 + nsteps;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || pairs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pairs_due.size() != 0) begin
      $display("%0t ns: pixel pairs never produced, expected %0d more, actual 0",
               $time, pairs_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("antialiased_line_stepper_test: done, clean");
    end else begin
      $display("antialiased_line_stepper_test: done, errors");
    end
    $finish;
  end

endmodule
